// ===== src/wsd_pkg.sv =====
`default_nettype none

package wsd_pkg;

    // parse phases
    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_PAY  = 3'd4;

    // result kinds
    localparam logic [2:0] K_DATA  = 3'd0;
    localparam logic [2:0] K_PING  = 3'd1;
    localparam logic [2:0] K_EMPTY = 3'd2;
    localparam logic [2:0] K_CLOSE = 3'd3;
    localparam logic [2:0] K_BAD   = 3'd4;

    // opcodes
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic       message_is_text;
        logic       frame_last;
        logic       message_last;
    } wsd_result_t;

    function automatic logic is_data_op(input logic [3:0] op);
        return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN);
    endfunction

endpackage

`default_nettype wire

// ===== src/wsd_in_stage.sv =====
`default_nettype none

module wsd_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       advance,
    output logic            stage_valid,
    output logic [7:0]      stage_byte
);
    import wsd_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;

    // stage empties whenever the parser takes its byte
    assign in_ready    = !valid_reg || advance;
    assign stage_valid = valid_reg;
    assign stage_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

`default_nettype wire

// ===== src/wsd_parser.sv =====
`default_nettype none

module wsd_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    b,
    output logic               res_valid,
    output wsd_pkg::wsd_result_t res
);
    import wsd_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        fin_reg, fin_next;
    logic [3:0]  op_reg, op_next;
    logic        mask_reg, mask_next;
    logic        ext64_reg, ext64_next;
    logic [63:0] len_reg, len_next;   // length during header, bytes left in payload
    logic [1:0]  idx_reg, idx_next;   // key byte select
    logic [31:0] key_reg, key_next;
    logic        text_reg, text_next;

    logic        finish;
    logic        emit;
    logic [2:0]  emit_kind;
    logic [7:0]  emit_byte;
    logic        emit_last;
    logic [3:0]  cnt_inc;
    logic [3:0]  ext_need;
    logic [7:0]  key_byte;
    logic        pay_last;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        fin_next   = fin_reg;
        op_next    = op_reg;
        mask_next  = mask_reg;
        ext64_next = ext64_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        key_next   = key_reg;
        text_next  = text_reg;
        finish     = 1'b0;
        emit       = 1'b0;
        emit_kind  = K_DATA;
        emit_byte  = 8'h00;
        emit_last  = 1'b0;
        cnt_inc    = cnt_reg + 4'd1;
        ext_need   = ext64_reg ? EXT64_BYTES : EXT16_BYTES;
        pay_last   = (len_reg == 64'd1);

        unique case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase

        unique case (phase_reg)
            PH_HDR0:
            begin
                fin_next = b[7];
                op_next  = b[3:0];
                if ((b[3:0] == OP_TEXT) || (b[3:0] == OP_BIN))
                begin
                    text_next = (b[3:0] == OP_TEXT);
                end
                key_next   = 32'h0;
                cnt_next   = 4'd0;
                phase_next = PH_HDR1;
            end
            PH_HDR1:
            begin
                mask_next  = b[7];
                ext64_next = (b[6:0] == LEN_EXT64);
                cnt_next   = 4'd0;
                if (b[6:0] >= LEN_EXT16)
                begin
                    len_next   = 64'd0;
                    phase_next = PH_EXT;
                end
                else
                begin
                    len_next = {57'd0, b[6:0]};
                    if (b[7])
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            PH_EXT:
            begin
                len_next = {len_reg[55:0], b};
                cnt_next = cnt_inc;
                if (cnt_inc >= ext_need)
                begin
                    cnt_next = 4'd0;
                    if (mask_reg)
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            PH_KEY:
            begin
                key_next = {key_reg[23:0], b};
                cnt_next = cnt_inc;
                if (cnt_inc >= KEY_BYTES)
                begin
                    finish = 1'b1;
                end
            end
            PH_PAY:
            begin
                len_next = len_reg - 64'd1;
                idx_next = idx_reg + 2'd1;
                if (pay_last)
                begin
                    phase_next = PH_HDR0;
                    idx_next   = 2'd0;
                end
                emit_last = pay_last;
                if (is_data_op(op_reg))
                begin
                    emit      = 1'b1;
                    emit_kind = K_DATA;
                    emit_byte = b ^ key_byte;
                end
                else if (op_reg == OP_PING)
                begin
                    emit      = 1'b1;
                    emit_kind = K_PING;
                    emit_byte = b ^ key_byte;
                end
                else if (pay_last && (op_reg != OP_PONG))
                begin
                    emit      = 1'b1;
                    emit_kind = (op_reg == OP_CLOSE) ? K_CLOSE : K_BAD;
                end
            end
            default:
            begin
                phase_next = PH_HDR0;
            end
        endcase

        // header complete
        if (finish)
        begin
            idx_next = 2'd0;
            cnt_next = 4'd0;
            if (len_next != 64'd0)
            begin
                phase_next = PH_PAY;
            end
            else
            begin
                phase_next = PH_HDR0;
                emit_last  = 1'b1;
                if (is_data_op(op_reg) || (op_reg == OP_PING))
                begin
                    emit      = 1'b1;
                    emit_kind = K_EMPTY;
                end
                else if (op_reg == OP_CLOSE)
                begin
                    emit      = 1'b1;
                    emit_kind = K_CLOSE;
                end
                else if (op_reg != OP_PONG)
                begin
                    emit      = 1'b1;
                    emit_kind = K_BAD;
                end
            end
        end
    end

    assign res_valid           = step && emit;
    assign res.kind            = emit_kind;
    assign res.data_byte       = emit_byte;
    assign res.message_is_text = text_reg;
    assign res.frame_last      = emit_last;
    assign res.message_last    = emit_last && fin_reg && is_data_op(op_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR0;
            cnt_reg   <= 4'd0;
            fin_reg   <= 1'b0;
            op_reg    <= OP_CONT;
            mask_reg  <= 1'b0;
            ext64_reg <= 1'b0;
            len_reg   <= 64'd0;
            idx_reg   <= 2'd0;
            key_reg   <= 32'h0;
            text_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            fin_reg   <= fin_next;
            op_reg    <= op_next;
            mask_reg  <= mask_next;
            ext64_reg <= ext64_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            key_reg   <= key_next;
            text_reg  <= text_next;
        end
    end

`ifndef ASSERT_OFF
    a_pay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAY) |-> (len_reg != 64'd0))
        else $error("payload phase with no bytes left");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < EXT64_BYTES)
        else $error("header byte count out of range");

    a_key_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_KEY) |-> mask_reg)
        else $error("key phase without mask bit");

    a_event_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.kind == K_EMPTY || res.kind == K_CLOSE || res.kind == K_BAD))
            |-> res.frame_last)
        else $error("frame event without frame end");

    a_msg_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.message_last) |-> res.frame_last)
        else $error("message end outside frame end");
`endif

endmodule

`default_nettype wire

// ===== src/wsd_out_stage.sv =====
`default_nettype none

module wsd_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 res_valid,
    input  wire wsd_pkg::wsd_result_t res,
    output logic                      advance,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [2:0]                kind,
    output logic [7:0]                data_byte,
    output logic                      message_is_text,
    output logic                      frame_last,
    output logic                      message_last
);
    import wsd_pkg::*;

    logic        valid_reg;
    wsd_result_t data_reg;

    // register is free when empty or being drained this cycle
    assign advance = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign out_valid       = valid_reg;
    assign kind            = data_reg.kind;
    assign data_byte       = data_reg.data_byte;
    assign message_is_text = data_reg.message_is_text;
    assign frame_last      = data_reg.frame_last;
    assign message_last    = data_reg.message_last;

endmodule

`default_nettype wire

// ===== src/websocket_frame_deframer_unit.sv =====
// Channel  Dir  Handshake              Payload
// input    in   in_valid / in_ready    rx_byte[7:0]
// result   out  out_valid / out_ready  kind, data_byte, message_is_text, frame_last, message_last
//
// One byte per clock sustained while the result register is not stalled; a byte waits in
// the input register while the parser works on it, and its result (if any) is loaded into
// the result register at the same edge at which the parser takes the byte.
// rst_n is asynchronous, active low; it returns the parser to the first header byte.
// A stalled result register holds the parser and the input register, also for bytes
// that give no result; in_ready follows out_ready combinationally. No byte is dropped.
`default_nettype none

module websocket_frame_deframer_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      kind,
    output logic [7:0]      data_byte,
    output logic            message_is_text,
    output logic            frame_last,
    output logic            message_last
);
    import wsd_pkg::*;

    logic        advance;      // result register can take a new transaction
    logic        stage_valid;
    logic [7:0]  stage_byte;
    logic        step;         // parser consumes the staged byte
    logic        res_valid;
    wsd_result_t res;

    assign step = stage_valid && advance;

    wsd_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_byte  (stage_byte)
    );

    // header decode, unmasking and frame/message end flags
    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .b         (stage_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_stage u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .res_valid       (res_valid),
        .res             (res),
        .advance         (advance),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .data_byte       (data_byte),
        .message_is_text (message_is_text),
        .frame_last      (frame_last),
        .message_last    (message_last)
    );

endmodule

`default_nettype wire

// ===== sim/wsd_frame_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels, predicts the deframer result stream, compares in order.
module wsd_frame_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [2:0] kind,
    input  logic [7:0] data_byte,
    input  logic       message_is_text,
    input  logic       frame_last,
    input  logic       message_last,
    output int         mismatches,
    output int         outstanding
);

    import wsd_pkg::*;

    // predicted parser state
    logic [2:0]  phase;
    logic [3:0]  hdr_cnt;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [6:0]  len7;
    logic [63:0] pay_len;
    logic [63:0] pay_idx;
    logic [31:0] key;
    logic        text_msg;

    wsd_result_t deframed_q[$];
    wsd_result_t want;

    function automatic logic carries_data(input logic [3:0] op);
        return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN);
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: MISMATCH %s", $time, what);
        mismatches++;
    endtask

    task automatic push_result(input logic [2:0] k, input logic [7:0] d, input logic flast);
        wsd_result_t r;
        r.kind            = k;
        r.data_byte       = d;
        r.message_is_text = text_msg;
        r.frame_last      = flast;
        r.message_last    = flast && fin && carries_data(opcode);
        deframed_q.insert(deframed_q.size(), r);
    endtask

    task automatic finish_header();
        pay_idx = '0;
        hdr_cnt = '0;
        if (pay_len != 64'd0)
        begin
            phase = PH_PAY;
        end
        else
        begin
            phase = PH_HDR0;
            if (carries_data(opcode) || opcode == OP_PING)
                push_result(K_EMPTY, 8'h00, 1'b1);
            else if (opcode == OP_CLOSE)
                push_result(K_CLOSE, 8'h00, 1'b1);
            else if (opcode != OP_PONG)
                push_result(K_BAD, 8'h00, 1'b1);
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [1:0] lane;
        logic [7:0] plain;
        logic       last;
        case (phase)
            PH_HDR0:
            begin
                fin    = b[7];
                opcode = b[3:0];
                if (opcode == OP_TEXT || opcode == OP_BIN)
                    text_msg = (opcode == OP_TEXT);
                key     = '0;
                hdr_cnt = '0;
                phase   = PH_HDR1;
            end
            PH_HDR1:
            begin
                masked  = b[7];
                len7    = b[6:0];
                hdr_cnt = '0;
                if (len7 >= LEN_EXT16)
                begin
                    pay_len = '0;
                    phase   = PH_EXT;
                end
                else
                begin
                    pay_len = 64'(len7);
                    if (masked)
                        phase = PH_KEY;
                    else
                        finish_header();
                end
            end
            PH_EXT:
            begin
                pay_len = {pay_len[55:0], b};
                hdr_cnt = hdr_cnt + 4'd1;
                if (hdr_cnt == ((len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES))
                begin
                    hdr_cnt = '0;
                    if (masked)
                        phase = PH_KEY;
                    else
                        finish_header();
                end
            end
            PH_KEY:
            begin
                key     = {key[23:0], b};
                hdr_cnt = hdr_cnt + 4'd1;
                if (hdr_cnt == KEY_BYTES)
                    finish_header();
            end
            PH_PAY:
            begin
                lane    = pay_idx[1:0];
                plain   = b ^ key[8*(3-lane) +: 8];
                last    = (pay_idx + 64'd1 == pay_len);
                pay_idx = pay_idx + 64'd1;
                if (last)
                begin
                    phase   = PH_HDR0;
                    pay_idx = '0;
                end
                if (carries_data(opcode))
                    push_result(K_DATA, plain, last);
                else if (opcode == OP_PING)
                    push_result(K_PING, plain, last);
                else if (last && opcode == OP_CLOSE)
                    push_result(K_CLOSE, 8'h00, 1'b1);
                else if (last && opcode != OP_PONG)
                    push_result(K_BAD, 8'h00, 1'b1);
            end
            default:
                phase = PH_HDR0;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase    = PH_HDR0;
            hdr_cnt  = '0;
            fin      = 1'b0;
            opcode   = OP_CONT;
            masked   = 1'b0;
            len7     = '0;
            pay_len  = '0;
            pay_idx  = '0;
            key      = '0;
            text_msg = 1'b0;
            deframed_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // a result always trails its own byte, so compare before predicting
            if (out_valid && out_ready)
            begin
                if (deframed_q.size() == 0)
                begin
                    report_mismatch($sformatf("result kind %0d with nothing expected", kind));
                end
                else
                begin
                    want = deframed_q.pop_front();
                    if (kind != want.kind)
                        report_mismatch($sformatf("kind %0d want %0d", kind, want.kind));
                    if (data_byte != want.data_byte)
                        report_mismatch($sformatf("data_byte %02h want %02h",
                                                  data_byte, want.data_byte));
                    if (message_is_text != want.message_is_text)
                        report_mismatch($sformatf("message_is_text %0b want %0b",
                                                  message_is_text, want.message_is_text));
                    if (frame_last != want.frame_last)
                        report_mismatch($sformatf("frame_last %0b want %0b",
                                                  frame_last, want.frame_last));
                    if (message_last != want.message_last)
                        report_mismatch($sformatf("message_last %0b want %0b",
                                                  message_last, want.message_last));
                end
            end
            if (in_valid && in_ready)
                deframe_byte(rx_byte);
            outstanding <= deframed_q.size();
        end
    end

endmodule

// ===== sim/tb_websocket_frame_deframer_unit.sv =====
`timescale 1ns / 100ps

// Byte-stream stimulus for the deframer. The checker beside the DUT does all
// prediction and comparison; this module only drives traffic and decides the verdict.
module tb_websocket_frame_deframer_unit;

    import wsd_pkg::*;

    // length encodings of the second header byte
    localparam int LF_SHORT = 0;
    localparam int LF_EXT16 = 1;
    localparam int LF_EXT64 = 2;

    // an undefined opcode at the top of the range
    localparam logic [3:0] OP_BAD_TOP = 4'hF;

    localparam int RANDOM_BYTES = 650;
    // cycles with no transaction on either channel before the run is declared hung
    localparam int STALL_LIMIT  = 1000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_ready = 1'b0;

    logic       in_ready;
    logic       out_valid;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       message_is_text;
    logic       frame_last;
    logic       message_last;

    int   fail_count;
    int   outstanding;
    int   sent;
    int   idle_cycles;
    int   ready_left;
    int   stall;
    logic tx_calm;
    logic drained;

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    websocket_frame_deframer_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .data_byte       (data_byte),
        .message_is_text (message_is_text),
        .frame_last      (frame_last),
        .message_last    (message_last)
    );

    wsd_frame_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .data_byte       (data_byte),
        .message_is_text (message_is_text),
        .frame_last      (frame_last),
        .message_last    (message_last),
        .mismatches      (fail_count),
        .outstanding     (outstanding)
    );

    // Idle length between transactions: mostly none, some short, a few long.
    // A calm stretch forces back-to-back traffic.
    function automatic int pick_gap(input logic calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side backpressure. All changes land on the falling edge so the DUT
    // sees a stable out_ready at every rising edge.
    always @(negedge clk)
    begin
        if (ready_left != 0)
        begin
            ready_left <= ready_left - 1;
        end
        else if (out_ready)
        begin
            stall = pick_gap(1'b0);
            if (stall == 0)
                ready_left <= $urandom_range(0, 15);
            else
            begin
                out_ready  <= 1'b0;
                ready_left <= stall - 1;
            end
        end
        else
        begin
            out_ready  <= 1'b1;
            // now and then a long stretch with no stalls at all
            ready_left <= ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(0, 15);
        end
    end

    // Hang detector: counts cycles with no transaction on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // One input transaction. Valid drops only across an actual gap, so back-to-back
    // bytes keep in_valid high with a single assignment per step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(tx_calm);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        // in_ready read right after the edge still holds its pre-edge value
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    // Header, optional extended length, optional key, then n_pay random payload bytes.
    // n_pay may differ from len to leave a frame open.
    task automatic send_frame(input logic [7:0] hdr0, input logic mask_on, input int form,
                              input logic [63:0] len, input int n_pay);
        send_byte(hdr0);
        case (form)
            LF_EXT16:
            begin
                send_byte({mask_on, LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            LF_EXT64:
            begin
                send_byte({mask_on, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
            default:
                send_byte({mask_on, len[6:0]});
        endcase
        if (mask_on)
            repeat (KEY_BYTES) send_byte(8'($urandom));
        repeat (n_pay) send_byte(8'($urandom));
    endtask

    // Complete frame with a random length encoding; mostly short payloads,
    // occasionally a long 16-bit extended one, non-minimal encodings included.
    task automatic random_frame(input logic [3:0] op, input logic fin);
        logic [2:0]  rsv;
        logic        mask_on;
        logic [63:0] len;
        int          form;
        int          r;
        rsv     = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'b000;
        mask_on = ($urandom_range(0, 2) != 0);
        tx_calm = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            form = LF_SHORT;
            len  = 64'($urandom_range(0, 12));
        end
        else if (r < 65)
        begin
            form = LF_SHORT;
            len  = 64'($urandom_range(100, 125));
        end
        else if (r < 82)
        begin
            form = LF_EXT16;
            len  = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(126, 300))
                                               : 64'($urandom_range(0, 30));
        end
        else
        begin
            form = LF_EXT64;
            len  = 64'($urandom_range(0, 20));
        end
        send_frame({fin, rsv, op}, mask_on, form, len, int'(len));
    endtask

    function automatic logic [3:0] random_control_op();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            return OP_PING;
        if (r == 1)
            return OP_PONG;
        return OP_CLOSE;
    endfunction

    function automatic logic [3:0] random_bad_op();
        logic [3:0] op;
        // 3..12 mapped onto 3..7 and 11..15
        op = 4'($urandom_range(3, 12));
        if (op > 4'd7)
            op = op + 4'd3;
        return op;
    endfunction

    // Well-formed message: text or binary start, continuations, FIN on the last
    // fragment, control frames sometimes interleaved between fragments.
    task automatic send_message();
        int         nfrag;
        logic [3:0] op;
        nfrag = $urandom_range(1, 3);
        for (int i = 0; i < nfrag; i++)
        begin
            if (i == 0)
                op = $urandom_range(0, 1) ? OP_TEXT : OP_BIN;
            else
                op = OP_CONT;
            random_frame(op, i == nfrag - 1);
            if (i < nfrag - 1 && $urandom_range(0, 3) == 0)
                random_frame(random_control_op(), 1'b1);
        end
    endtask

    // Broken traffic: any opcode, any FIN - stray continuations, fragmented
    // control frames, undefined opcodes.
    task automatic send_noise_frame();
        logic [3:0] op;
        int         r;
        r = $urandom_range(0, 3);
        if (r == 0)
            op = random_bad_op();
        else if (r == 1)
            op = random_control_op();
        else
            op = 4'($urandom_range(0, 2));
        random_frame(op, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        sent    = 0;
        tx_calm = 1'b0;
        drained = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed ----
        // text start without FIN, unmasked single byte
        send_frame({1'b0, 3'b000, OP_TEXT}, 1'b0, LF_SHORT, 64'd1, 1);
        // masked continuation closes the message
        send_frame({1'b1, 3'b000, OP_CONT}, 1'b1, LF_SHORT, 64'd2, 2);
        // empty ping
        send_frame({1'b1, 3'b000, OP_PING}, 1'b0, LF_SHORT, 64'd0, 0);
        // pong with payload: swallowed silently
        send_frame({1'b1, 3'b000, OP_PONG}, 1'b0, LF_SHORT, 64'd1, 1);
        // empty close, then close carrying a byte
        send_frame({1'b1, 3'b000, OP_CLOSE}, 1'b0, LF_SHORT, 64'd0, 0);
        send_frame({1'b1, 3'b000, OP_CLOSE}, 1'b0, LF_SHORT, 64'd1, 1);
        // all-ones header byte: RSV set, undefined opcode, empty
        send_frame({1'b1, 3'b111, OP_BAD_TOP}, 1'b0, LF_SHORT, 64'd0, 0);
        // empty masked binary frame: header ends on the last key byte
        send_frame({1'b1, 3'b000, OP_BIN}, 1'b1, LF_SHORT, 64'd0, 0);

        // ---- random ----
        while (sent < RANDOM_BYTES)
        begin
            // once, halfway: hold the sender until every result is back
            if (!drained && sent >= RANDOM_BYTES / 2)
            begin
                drained = 1'b1;
                @(negedge clk);
                in_valid <= 1'b0;
                while (outstanding != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 99) < 15)
                send_noise_frame();
            else
                send_message();
        end

        // Left open: 64-bit length with the top bit and bit 32 set. Only a handful
        // of payload bytes go in, so none may be flagged as the frame end.
        tx_calm = 1'b0;
        send_frame({1'b1, 3'b000, OP_BIN}, 1'b1, LF_EXT64, 64'h8000_0001_0000_0002, 12);

        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (outstanding != 0)
            $display("%0d results never arrived", outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
src/wsd_pkg.sv
src/wsd_in_stage.sv
src/wsd_parser.sv
src/wsd_out_stage.sv
src/websocket_frame_deframer_unit.sv
sim/wsd_frame_checker.sv
sim/tb_websocket_frame_deframer_unit.sv
